// ===== sv/wsrl_pkg.sv =====
// Shared types and constants of the wheel step rate limiter.
package wsrl_pkg;

    // Field and state widths
    localparam int FRAC_BITS  = 4;
    localparam int TIMER_W    = 16;
    localparam int DELTA_W    = 10;
    localparam int STEP_W     = 4;
    localparam int ACC_W      = 8;
    localparam int LIM_W      = 7;
    localparam int SUM_W      = DELTA_W + 1;
    localparam int STEP_MAG_W = 3;
    localparam int STEP_SAT   = 7;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    // Register indexes
    localparam logic [2:0] REG_IDLE_RESET = 3'd0;
    localparam logic [2:0] REG_BAND_ONE   = 3'd1;
    localparam logic [2:0] REG_BAND_TWO   = 3'd2;
    localparam logic [2:0] REG_IV_SLOW    = 3'd3;
    localparam logic [2:0] REG_IV_MID     = 3'd4;
    localparam logic [2:0] REG_IV_FAST    = 3'd5;
    localparam logic [2:0] REG_ACC_LIMIT  = 3'd6;

    // Register reset values
    localparam logic [TIMER_W-1:0] RST_IDLE_RESET = 16'd300;
    localparam logic [TIMER_W-1:0] RST_BAND_ONE   = 16'd300;
    localparam logic [TIMER_W-1:0] RST_BAND_TWO   = 16'd600;
    localparam logic [TIMER_W-1:0] RST_IV_SLOW    = 16'd100;
    localparam logic [TIMER_W-1:0] RST_IV_MID     = 16'd50;
    localparam logic [TIMER_W-1:0] RST_IV_FAST    = 16'd25;
    localparam logic [LIM_W-1:0]   RST_ACC_LIMIT  = 7'd32;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [TIMER_W-1:0] idle_reset;
        logic [TIMER_W-1:0] band_one;
        logic [TIMER_W-1:0] band_two;
        logic [TIMER_W-1:0] iv_slow;
        logic [TIMER_W-1:0] iv_mid;
        logic [TIMER_W-1:0] iv_fast;
        logic [LIM_W-1:0]   acc_limit;
    } t_cfg;

    // Classified item held in the queue
    typedef struct packed {
        logic                      zero;
        logic                      neg;
        logic signed [DELTA_W-1:0] delta;
    } t_item;

    // Divider handshake
    typedef struct packed {
        logic                  done;
        logic [STEP_MAG_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== sv/wheel_step_rate_limiter_top.sv =====
// Top level of the wheel step rate limiter: register file, front end and back end.
// One result item leaves for every tick item taken. A tick with a zero delta goes
// straight to the output register, one that carries no whole notch or finds the emit
// timer stopped goes there from the prepare state, and any other waits for the step
// limit, a quotient by repeated subtraction that stops at seven. The back end takes
// the next tick once it has loaded a result into the output register. A two-entry
// queue lets the front end take further ticks while the back end works, and the
// output register lets the back end start the next tick while a result waits to be
// taken.
module wheel_step_rate_limiter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [wsrl_pkg::DELTA_W-1:0] i_wheel_delta,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [wsrl_pkg::STEP_W-1:0]  o_cursor_step,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wsrl_pkg::ADDR_W-1:0]         paddr,
    input  logic [wsrl_pkg::DATA_W-1:0]         pwdata,
    output logic [wsrl_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import wsrl_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic       pop;
    logic       empty;
    t_item      item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_reset <= RST_IDLE_RESET;
            r_cfg.band_one   <= RST_BAND_ONE;
            r_cfg.band_two   <= RST_BAND_TWO;
            r_cfg.iv_slow    <= RST_IV_SLOW;
            r_cfg.iv_mid     <= RST_IV_MID;
            r_cfg.iv_fast    <= RST_IV_FAST;
            r_cfg.acc_limit  <= RST_ACC_LIMIT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IDLE_RESET: r_cfg.idle_reset <= pwdata[TIMER_W-1:0];
                REG_BAND_ONE:   r_cfg.band_one   <= pwdata[TIMER_W-1:0];
                REG_BAND_TWO:   r_cfg.band_two   <= pwdata[TIMER_W-1:0];
                REG_IV_SLOW:    r_cfg.iv_slow    <= pwdata[TIMER_W-1:0];
                REG_IV_MID:     r_cfg.iv_mid     <= pwdata[TIMER_W-1:0];
                REG_IV_FAST:    r_cfg.iv_fast    <= pwdata[TIMER_W-1:0];
                REG_ACC_LIMIT:  r_cfg.acc_limit  <= pwdata[LIM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (reg_idx)
            REG_IDLE_RESET: prdata = DATA_W'(r_cfg.idle_reset);
            REG_BAND_ONE:   prdata = DATA_W'(r_cfg.band_one);
            REG_BAND_TWO:   prdata = DATA_W'(r_cfg.band_two);
            REG_IV_SLOW:    prdata = DATA_W'(r_cfg.iv_slow);
            REG_IV_MID:     prdata = DATA_W'(r_cfg.iv_mid);
            REG_IV_FAST:    prdata = DATA_W'(r_cfg.iv_fast);
            REG_ACC_LIMIT:  prdata = DATA_W'(r_cfg.acc_limit);
            default:        prdata = '0;
        endcase
    end

    wsrl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_wheel_delta (i_wheel_delta),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_item        (item)
    );

    wsrl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (empty),
        .i_item        (item),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cursor_step (o_cursor_step)
    );

endmodule

// ===== sv/wsrl_front.sv =====
// Front end: accepts ticks, classifies the delta and queues the item.
module wsrl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [wsrl_pkg::DELTA_W-1:0] i_wheel_delta,
    input  logic                               i_pop,
    output logic                               o_empty,
    output wsrl_pkg::t_item                    o_item
);
    import wsrl_pkg::*;

    t_item       r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    logic        pop;
    t_item       cls;

    // Classify the delta
    always_comb begin
        cls.zero  = (i_wheel_delta == '0);
        cls.neg   = i_wheel_delta[DELTA_W-1];
        cls.delta = i_wheel_delta;
    end

    assign o_in_ready = (r_count != 2'd2);
    assign o_empty    = (r_count == 2'd0);
    assign o_item     = r_q[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_pop && !o_empty;

    // Two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/wsrl_div.sv =====
// Quotient of the emit timer by the interval, one subtraction a cycle, capped.
module wsrl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wsrl_pkg::TIMER_W-1:0]  i_dividend,
    input  logic [wsrl_pkg::TIMER_W-1:0]  i_divisor,
    output wsrl_pkg::t_div_rsp            o_rsp
);
    import wsrl_pkg::*;

    logic                  r_busy;
    logic [TIMER_W-1:0]    r_rem;
    logic [TIMER_W-1:0]    r_div;
    logic [STEP_MAG_W-1:0] r_quot;
    logic                  can_sub;

    // Stop at the cap or when the remainder falls below the divisor
    assign can_sub = (r_rem >= r_div) && (r_quot != STEP_MAG_W'(STEP_SAT));
    assign o_rsp.done = r_busy && !can_sub;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_rsp.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy && can_sub) begin
            r_rem  <= r_rem - r_div;
            r_quot <= r_quot + STEP_MAG_W'(1);
        end
    end

endmodule

// ===== sv/wsrl_back.sv =====
// Back end: timers, accumulator, step limiting and the output register.
module wsrl_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wsrl_pkg::t_cfg                     i_cfg,
    input  logic                               i_empty,
    input  wsrl_pkg::t_item                    i_item,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [wsrl_pkg::STEP_W-1:0] o_cursor_step
);
    import wsrl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                   r_state, n_state;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [TIMER_W-1:0]       r_idle_t, n_idle_t;
    logic [TIMER_W-1:0]       r_run_t, n_run_t;
    logic [TIMER_W-1:0]       r_emit_t, n_emit_t;
    logic                     r_idle_run, n_idle_run;
    logic                     r_run_run, n_run_run;
    logic                     r_emit_run, n_emit_run;
    logic [STEP_MAG_W-1:0]    r_steps, n_steps;
    logic                     r_neg, n_neg;
    logic signed [STEP_W-1:0] r_res, n_res;
    logic                     r_o_valid, n_o_valid;
    logic signed [STEP_W-1:0] r_o_step, n_o_step;

    logic                     div_start;
    t_div_rsp                 div_rsp;
    logic [TIMER_W-1:0]       iv;
    logic                     apply_en;
    logic [STEP_MAG_W-1:0]    maxs;

    // Saturating timer tick
    function automatic logic [TIMER_W-1:0] tick_up(logic [TIMER_W-1:0] t, logic run);
        logic [TIMER_W-1:0] r;
        r = t;
        if (run && (t != '1)) r = t + TIMER_W'(1);
        return r;
    endfunction

    // Emit interval from the run-time band, zero acts as one
    always_comb begin
        if (r_run_t < i_cfg.band_one)      iv = i_cfg.iv_slow;
        else if (r_run_t < i_cfg.band_two) iv = i_cfg.iv_mid;
        else                               iv = i_cfg.iv_fast;
        if (iv == '0) iv = TIMER_W'(1);
    end

    wsrl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_emit_t),
        .i_divisor  (iv),
        .o_rsp      (div_rsp)
    );

    // Sequencer and state update
    always_comb begin
        logic [TIMER_W-1:0]      idle_t;
        logic [TIMER_W-1:0]      run_t;
        logic [TIMER_W-1:0]      emit_t;
        logic signed [ACC_W-1:0] acc_base;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] lim;
        logic signed [ACC_W-1:0] clamped;
        logic [ACC_W-1:0]        mag;
        logic [STEP_MAG_W-1:0]   take;
        logic [ACC_W-1:0]        sub;

        n_state    = r_state;
        n_acc      = r_acc;
        n_idle_t   = r_idle_t;
        n_run_t    = r_run_t;
        n_emit_t   = r_emit_t;
        n_idle_run = r_idle_run;
        n_run_run  = r_run_run;
        n_emit_run = r_emit_run;
        n_steps    = r_steps;
        n_neg      = r_neg;
        n_res      = r_res;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_step   = r_o_step;
        o_pop      = 1'b0;
        div_start  = 1'b0;
        apply_en   = 1'b0;
        maxs       = '0;

        idle_t   = tick_up(r_idle_t, r_idle_run);
        run_t    = tick_up(r_run_t, r_run_run);
        emit_t   = tick_up(r_emit_t, r_emit_run);
        acc_base = r_acc;
        lim      = SUM_W'(i_cfg.acc_limit);
        sum      = '0;
        clamped  = '0;
        mag      = '0;
        take     = '0;
        sub      = '0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_idle_t = idle_t;
                    n_run_t  = run_t;
                    n_emit_t = emit_t;
                    if (i_item.zero) begin
                        // Long idle clears the accumulator and stops the run and emit timers
                        if (idle_t > i_cfg.idle_reset) begin
                            n_acc      = '0;
                            n_run_t    = '0;
                            n_run_run  = 1'b0;
                            n_emit_t   = '0;
                            n_emit_run = 1'b0;
                        end
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_idle_t   = '0;
                        n_idle_run = 1'b1;
                        if (!r_run_run) begin
                            n_run_t   = '0;
                            n_run_run = 1'b1;
                        end
                        // Direction reversal
                        if ((r_acc != '0) && (r_acc[ACC_W-1] != i_item.neg)) begin
                            acc_base  = '0;
                            n_run_t   = '0;
                            n_run_run = 1'b1;
                        end
                        sum = SUM_W'(acc_base) + SUM_W'(i_item.delta);
                        if (sum > lim)       clamped = ACC_W'(lim);
                        else if (sum < -lim) clamped = ACC_W'(-lim);
                        else                 clamped = ACC_W'(sum);
                        mag     = clamped[ACC_W-1] ? ACC_W'(-clamped) : ACC_W'(clamped);
                        n_acc   = clamped;
                        n_neg   = clamped[ACC_W-1];
                        n_steps = STEP_MAG_W'(mag >> FRAC_BITS);
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                if (r_steps == '0) begin
                    n_res   = '0;
                    n_state = S_OUT;
                end else if (!r_emit_run) begin
                    apply_en = 1'b1;
                    maxs     = STEP_MAG_W'(1);
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    apply_en = 1'b1;
                    maxs     = div_rsp.quot;
                end
            end
            S_OUT: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid = 1'b1;
                    n_o_step  = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Limit the steps, emit them and take them off the accumulator
        if (apply_en) begin
            n_state = S_OUT;
            if (maxs == '0) begin
                n_res = '0;
            end else begin
                take       = (r_steps > maxs) ? maxs : r_steps;
                sub        = ACC_W'(take) << FRAC_BITS;
                n_acc      = r_neg ? (r_acc + $signed(sub)) : (r_acc - $signed(sub));
                n_emit_t   = '0;
                n_emit_run = 1'b1;
                n_res      = r_neg ? -$signed({1'b0, take}) : $signed({1'b0, take});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_acc      <= '0;
            r_idle_t   <= '0;
            r_run_t    <= '0;
            r_emit_t   <= '0;
            r_idle_run <= 1'b0;
            r_run_run  <= 1'b0;
            r_emit_run <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_acc      <= n_acc;
            r_idle_t   <= n_idle_t;
            r_run_t    <= n_run_t;
            r_emit_t   <= n_emit_t;
            r_idle_run <= n_idle_run;
            r_run_run  <= n_run_run;
            r_emit_run <= n_emit_run;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_steps  <= n_steps;
        r_neg    <= n_neg;
        r_res    <= n_res;
        r_o_step <= n_o_step;
    end

    assign o_out_valid   = r_o_valid;
    assign o_cursor_step = r_o_step;

endmodule

// ===== tb/tb_wheel_step_rate_limiter_top.sv =====
// Self-checking testbench for the wheel step rate limiter top level.
module tb_wheel_step_rate_limiter_top;
    import wsrl_pkg::*;

    localparam logic [2:0] REG_UNUSED      = 3'd7;
    localparam int         PHASES          = 10;
    localparam int         PHASE_ITEMS     = 157;
    localparam int         SETTLE_CYCLES   = 16;
    localparam int         WATCHDOG_CYCLES = 2000;

    // Tracks the limiter state per tick and holds the steps still owed by the block
    class step_tracker;
        logic [TIMER_W-1:0]        idle_limit, band_one, band_two;
        logic [TIMER_W-1:0]        iv_slow, iv_mid, iv_fast;
        logic [LIM_W-1:0]          acc_limit;
        logic signed [ACC_W-1:0]   acc_q;
        logic [TIMER_W-1:0]        idle_t, run_t, emit_t;
        bit                        idle_on, run_on, emit_on;
        logic signed [STEP_W-1:0]  expected_steps[$];
        int                        mismatches;

        function new();
            idle_limit = RST_IDLE_RESET;
            band_one   = RST_BAND_ONE;
            band_two   = RST_BAND_TWO;
            iv_slow    = RST_IV_SLOW;
            iv_mid     = RST_IV_MID;
            iv_fast    = RST_IV_FAST;
            acc_limit  = RST_ACC_LIMIT;
            acc_q      = '0;
            idle_t     = '0;
            run_t      = '0;
            emit_t     = '0;
            idle_on    = 1'b0;
            run_on     = 1'b0;
            emit_on    = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_IDLE_RESET: idle_limit = val[TIMER_W-1:0];
                REG_BAND_ONE:   band_one   = val[TIMER_W-1:0];
                REG_BAND_TWO:   band_two   = val[TIMER_W-1:0];
                REG_IV_SLOW:    iv_slow    = val[TIMER_W-1:0];
                REG_IV_MID:     iv_mid     = val[TIMER_W-1:0];
                REG_IV_FAST:    iv_fast    = val[TIMER_W-1:0];
                REG_ACC_LIMIT:  acc_limit  = val[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Saturating count-up of a running timer
        function logic [TIMER_W-1:0] bump(logic [TIMER_W-1:0] t, bit on);
            if (!on || t == '1)
                return t;
            return t + 1'b1;
        endfunction

        function void note_tick(logic signed [DELTA_W-1:0] delta);
            int d, lim, sum, mag, steps, maxs, iv;
            d      = int'(delta);
            lim    = int'(acc_limit);
            idle_t = bump(idle_t, idle_on);
            run_t  = bump(run_t, run_on);
            emit_t = bump(emit_t, emit_on);

            // Zero delta: only a long enough idle spell has any effect
            if (d == 0) begin
                if (idle_t > idle_limit) begin
                    acc_q   = '0;
                    run_t   = '0;
                    run_on  = 1'b0;
                    emit_t  = '0;
                    emit_on = 1'b0;
                end
                expected_steps.push_back('0);
                return;
            end
            idle_t  = '0;
            idle_on = 1'b1;
            if (!run_on) begin
                run_t  = '0;
                run_on = 1'b1;
            end

            // Direction reversal drops what was gathered and restarts the run
            if (acc_q != 0 && ((acc_q < 0) != (d < 0))) begin
                acc_q = '0;
                run_t = '0;
            end
            sum = int'(acc_q) + d;
            if (sum > lim)
                sum = lim;
            if (sum < -lim)
                sum = -lim;
            acc_q = ACC_W'(sum);

            mag   = (sum < 0) ? -sum : sum;
            steps = mag / (1 << FRAC_BITS);
            if (steps == 0) begin
                expected_steps.push_back('0);
                return;
            end

            // Rate limit from the run-time band
            if (emit_on) begin
                if (run_t < band_one)
                    iv = int'(iv_slow);
                else if (run_t < band_two)
                    iv = int'(iv_mid);
                else
                    iv = int'(iv_fast);
                if (iv == 0)
                    iv = 1;
                maxs = int'(emit_t) / iv;
                if (maxs > STEP_SAT)
                    maxs = STEP_SAT;
            end else begin
                maxs = 1;
            end
            if (maxs <= 0) begin
                expected_steps.push_back('0);
                return;
            end
            if (steps > maxs)
                steps = maxs;
            if (sum < 0)
                steps = -steps;
            acc_q   = ACC_W'(sum - steps * (1 << FRAC_BITS));
            emit_t  = '0;
            emit_on = 1'b1;
            expected_steps.push_back(STEP_W'(steps));
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_step(logic signed [STEP_W-1:0] got);
            logic signed [STEP_W-1:0] want;
            if (expected_steps.size() == 0) begin
                report($sformatf("cursor_step %0d with no tick outstanding", got));
                return;
            end
            want = expected_steps.pop_front();
            if (got !== want)
                report($sformatf("cursor_step got %0d, want %0d", got, want));
        endtask
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic signed [DELTA_W-1:0]  wheel_delta = '0;
    logic                       out_ready = 1'b0;
    logic                       psel      = 1'b0;
    logic                       penable   = 1'b0;
    logic                       pwrite    = 1'b0;
    logic [ADDR_W-1:0]          paddr     = '0;
    logic [DATA_W-1:0]          pwdata    = '0;
    wire                        o_in_ready;
    wire                        o_out_valid;
    wire signed [STEP_W-1:0]    o_cursor_step;
    wire [DATA_W-1:0]           prdata;
    wire                        pready;

    step_tracker sb = new();
    int          gap_pct    = 0;
    int          stall_pct  = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    wheel_step_rate_limiter_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_wheel_delta (wheel_delta),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_cursor_step (o_cursor_step),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 unit clock
    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Result side: random stall bursts that hold out_ready low
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready  = 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            out_ready  = 1'b0;
            stall_left = $urandom_range(0, 8);
        end else begin
            out_ready = 1'b1;
        end
    end

    // Result check
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready)
            sb.check_step(o_cursor_step);
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // One tick item, with an optional leading gap
    task automatic send_tick(logic signed [DELTA_W-1:0] d);
        int gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 9) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        wheel_delta = d;
        do @(posedge clk); while (!o_in_ready);
        sb.note_tick(d);
    endtask

    // Register write; unused upper data bits carry noise
    task automatic apb_write(logic [2:0] idx, logic [TIMER_W-1:0] val);
        logic [DATA_W-1:0] word;
        word = $urandom;
        if (idx == REG_ACC_LIMIT)
            word[LIM_W-1:0] = val[LIM_W-1:0];
        else
            word[TIMER_W-1:0] = val;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, word);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_config(logic [TIMER_W-1:0] idle, logic [TIMER_W-1:0] b1,
                                logic [TIMER_W-1:0] b2, logic [TIMER_W-1:0] slow,
                                logic [TIMER_W-1:0] mid, logic [TIMER_W-1:0] fast,
                                logic [TIMER_W-1:0] lim);
        apb_write(REG_IDLE_RESET, idle);
        apb_write(REG_BAND_ONE, b1);
        apb_write(REG_BAND_TWO, b2);
        apb_write(REG_IV_SLOW, slow);
        apb_write(REG_IV_MID, mid);
        apb_write(REG_IV_FAST, fast);
        apb_write(REG_ACC_LIMIT, lim);
    endtask

    // Drop valid and let the block drain before touching the registers
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random ticks, mostly same-direction runs so the timers get somewhere
    task automatic run_phase(int n);
        int  sent, kind, len, k, mag;
        bit  neg;
        logic signed [DELTA_W-1:0] d;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            len  = (kind == 6 || kind == 7) ? $urandom_range(1, 45) : $urandom_range(1, 30);
            neg  = $urandom_range(0, 1);
            for (k = 0; k < len && sent < n; k++) begin
                if (kind <= 5) begin
                    mag = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 511)
                                                      : $urandom_range(1, 24);
                    d = DELTA_W'(neg ? -mag : mag);
                end else if (kind <= 7) begin
                    d = '0;
                end else if (kind == 8) begin
                    mag = $urandom_range(1, 40);
                    d   = DELTA_W'((k % 2 == 1) ? -mag : mag);
                end else begin
                    d = DELTA_W'($urandom);
                end
                send_tick(d);
                sent++;
            end
        end
    endtask

    initial begin
        int p;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // A few ticks under the reset settings
        send_tick(10'sd511);
        send_tick(10'sd511);
        send_tick(-10'sd512);
        send_tick(10'sd0);
        settle();

        // Directed: no notch, stopped emit timer, zero interval, reversal, idle clear
        write_config(16'd10, 16'd4, 16'd8, 16'd3, 16'd2, 16'd0, 16'd127);
        send_tick(10'sd0);
        send_tick(10'sd8);
        send_tick(10'sd8);
        repeat (7) send_tick(10'sd0);
        send_tick(10'sd511);
        send_tick(-10'sd1);
        send_tick(-10'sd512);
        send_tick(-10'sd512);
        repeat (11) send_tick(10'sd0);

        for (p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: write_config('1, '1, '1, '1, '1, '1, 16'd64);
                1: write_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd16);
                2: write_config('0, '0, '0, '0, '0, '0, '0);
                3: begin
                    write_config(16'd20, 16'd10, 16'd30, 16'd4, 16'd2, 16'd1, 16'd127);
                    apb_write(REG_UNUSED, TIMER_W'($urandom));
                end
                default: write_config(TIMER_W'($urandom_range(2, 40)),
                                      TIMER_W'($urandom_range(1, 30)),
                                      TIMER_W'($urandom_range(1, 60)),
                                      TIMER_W'($urandom_range(0, 8)),
                                      TIMER_W'($urandom_range(0, 6)),
                                      TIMER_W'($urandom_range(0, 4)),
                                      TIMER_W'(($urandom_range(0, 3) == 0)
                                               ? $urandom_range(0, 127)
                                               : $urandom_range(16, 64)));
            endcase
            // No idling in the phases where p % 4 is 3, and none in the last one
            if (p == PHASES - 1 || p % 4 == 3) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(10, 40);
                stall_pct = $urandom_range(10, 40);
            end
            run_phase(PHASE_ITEMS);
        end

        settle();
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
